// File: src/pdmmc_pkg.sv
// package for the per-device min/max/count statistics block
// holds table sizes, field widths, limit values and controller/datapath link types
// no dependencies
`timescale 1ns / 1ps

package pdmmc_pkg;

  // table and field sizes
  localparam int DEVICE_COUNT = 64;
  localparam int DEV_W        = $clog2(DEVICE_COUNT);
  localparam int VALUE_WIDTH  = 32;
  localparam int COUNT_W      = 32;

  // one table entry: count, min, max
  localparam int ENTRY_W = COUNT_W + 2 * VALUE_WIDTH;

  // stream payload widths (rounded up to whole bytes)
  localparam int IN_FIELDS_W  = DEV_W + VALUE_WIDTH;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = COUNT_W + 2 * VALUE_WIDTH;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // limit values
  localparam logic [VALUE_WIDTH-1:0] VAL_LARGEST  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VAL_SMALLEST = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [COUNT_W-1:0]     COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0]     COUNT_ONE    = {{(COUNT_W-1){1'b0}}, 1'b1};

  // command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input transfer
    logic commit;  // write back the entry (records only) and load the result register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_status_t;

endpackage

// File: src/pdmmc_ctrl.sv
// controller state machine for the statistics block
// sequences capture, table read and write-back; depends on pdmmc_pkg
`timescale 1ns / 1ps

module pdmmc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  pdmmc_pkg::dp_status_t status,
  output pdmmc_pkg::ctrl_cmd_t  cmd
);
  import pdmmc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_READ   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands to the datapath
  assign s_tready   = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && s_tvalid;
  assign cmd.commit = (state == S_UPDATE) && status.out_free;

endmodule

// File: src/pdmmc_dp.sv
// datapath for the statistics block: input registers, entry table,
// seen flags, update logic and result register; depends on pdmmc_pkg
`timescale 1ns / 1ps

module pdmmc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pdmmc_pkg::ctrl_cmd_t              cmd,
  output pdmmc_pkg::dp_status_t             status,
  input  logic [pdmmc_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pdmmc_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                              m_tuser
);
  import pdmmc_pkg::*;

  // captured input transfer
  logic                          cmd_reg;
  logic [DEV_W-1:0]              dev_reg;
  logic signed [VALUE_WIDTH-1:0] value_reg;

  // entry table and seen flags
  logic [ENTRY_W-1:0]      mem [DEVICE_COUNT];
  logic [ENTRY_W-1:0]      rd_data;
  logic [DEVICE_COUNT-1:0] entry_valid;
  logic                    rd_valid;

  // fields of the entry read
  logic [COUNT_W-1:0]            rd_count;
  logic signed [VALUE_WIDTH-1:0] rd_min;
  logic signed [VALUE_WIDTH-1:0] rd_max;

  // updated entry
  logic                          new_valid;
  logic [COUNT_W-1:0]            new_count;
  logic signed [VALUE_WIDTH-1:0] new_min;
  logic signed [VALUE_WIDTH-1:0] new_max;
  logic                          do_write;

  // result register
  logic                   res_seen;
  logic [COUNT_W-1:0]     res_count;
  logic [VALUE_WIDTH-1:0] res_min;
  logic [VALUE_WIDTH-1:0] res_max;

  // capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_reg   <= s_tuser;
      dev_reg   <= s_tdata[DEV_W-1:0];
      value_reg <= s_tdata[DEV_W +: VALUE_WIDTH];
    end
  end

  // table read, registered; address is held until write-back
  always_ff @(posedge clk) begin
    rd_data <= mem[dev_reg];
  end

  // table write-back
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[dev_reg] <= {new_max, new_min, new_count};
    end
  end

  // seen flags
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (do_write) begin
      entry_valid[dev_reg] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= entry_valid[dev_reg];
  end

  assign rd_count = rd_data[COUNT_W-1:0];
  assign rd_min   = rd_data[COUNT_W +: VALUE_WIDTH];
  assign rd_max   = rd_data[COUNT_W + VALUE_WIDTH +: VALUE_WIDTH];

  // entry update: a record's first event seeds the entry, later ones widen it; a query leaves it as read
  always_comb begin
    new_valid = rd_valid;
    new_count = rd_count;
    new_min   = rd_min;
    new_max   = rd_max;
    if (cmd_reg == CMD_RECORD) begin
      new_valid = 1'b1;
      if (!rd_valid) begin
        new_count = COUNT_ONE;
        new_min   = value_reg;
        new_max   = value_reg;
      end else begin
        if (rd_count != COUNT_MAX) new_count = rd_count + COUNT_ONE;
        if (value_reg < rd_min) new_min = value_reg;
        if (value_reg > rd_max) new_max = value_reg;
      end
    end
  end

  assign do_write = cmd.commit && (cmd_reg == CMD_RECORD);

  // result register
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_seen <= new_valid;
      if (new_valid) begin
        res_count <= new_count;
        res_min   <= new_min;
        res_max   <= new_max;
      end else begin
        res_count <= '0;
        res_min   <= VAL_LARGEST;
        res_max   <= VAL_SMALLEST;
      end
    end
  end

  assign m_tuser = res_seen;
  assign m_tdata = OUT_DATA_W'({res_max, res_min, res_count});

endmodule

// File: src/per_device_min_max_count.sv
// top level of the per-device min/max/count statistics block
// joins the controller and datapath; depends on pdmmc_pkg, pdmmc_ctrl, pdmmc_dp
//
//   side     dir  payload
//   s_*      in   tuser = command; tdata = device_id, sample_value
//   m_*      out  tuser = seen; tdata = event_count, min_value, max_value
//
// each item passes through capture, registered table read and write-back, in that order
// these steps come from the single read-modify-write of the entry table
// rst clears the seen flags and the state machine; the table itself is not cleared
// a new transfer is taken while a result still waits in the output register;
// write-back stalls only when that register is still full and m_tready is low
`timescale 1ns / 1ps

module per_device_min_max_count (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [37:6] sample_value, [5:0] device_id
  input  logic [pdmmc_pkg::IN_DATA_W-1:0]   s_tdata,
  // [0] command
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [95:64] max_value, [63:32] min_value, [31:0] event_count
  output logic [pdmmc_pkg::OUT_DATA_W-1:0]  m_tdata,
  // [0] seen
  output logic                              m_tuser
);
  import pdmmc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller
  pdmmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  pdmmc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
